// ----- hdl/sfr_pkg.sv -----
// Shared types, codes and the CRC-8 byte step for the sensor frame receiver.
// No dependencies; RTL takes names from here by scope, the testbench imports.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int FRAME_BYTES = 14;
	localparam int POS_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] HDR_FIRST = 8'h55;
	localparam logic [7:0] HDR_SECOND = 8'hAA;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] STATUS_MAX = 8'd2;
	localparam logic [7:0] STATUS_LOST = 8'd0;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TIME = 2'd1,
		OP_OVERFLOW = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_VALID = 3'd0,
		EV_RECOVERED = 3'd1,
		EV_CRC_ERR = 3'd2,
		EV_STATUS_ERR = 3'd3,
		EV_TIMEOUT = 3'd4
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT_LIMIT = 1'd0,
		REG_LOST_PIXEL = 1'd1
	} reg_idx_t;

	typedef enum logic {
		JOB_FRAME = 1'b0,
		JOB_TIME = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic crc_ok;
		logic [7:0] status;
		logic [7:0] seq;
		logic [15:0] pos;
		logic [15:0] vel;
		logic [7:0] conf;
		logic [15:0] px;
		logic [15:0] py;
		logic [31:0] now;
	} job_t;

	typedef struct packed {
		event_t ev;
		logic [1:0] status;
		logic [7:0] seq;
		logic [15:0] pos;
		logic [15:0] vel;
		logic [7:0] conf;
		logic [15:0] px;
		logic [15:0] py;
		logic adv;
		logic gap;
		logic lost_ok;
		logic [31:0] age;
	} result_t;

	function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] v;
		v = c ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- hdl/sfr_front.sv -----
// Front end: header hunt, byte collection and running CRC; emits frame and time-check jobs.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [1:0]          operation,
	input  logic [7:0]          rx_byte,
	input  logic [31:0]         now_ms,
	output logic                push,
	output sfr_pkg::job_t       job
);

	logic [sfr_pkg::POS_W-1:0] pos_q;
	logic [7:0]                crc_q;
	logic [7:0]                frame_q [2:sfr_pkg::FRAME_BYTES-2];

	logic [sfr_pkg::POS_W-1:0] pos_d;
	logic [7:0]                crc_d;
	logic                      store_en;
	logic                      last_byte;
	logic [7:0]                crc_first;

	assign crc_first = sfr_pkg::crc_step(8'd0, rx_byte);
	assign last_byte = (pos_q == sfr_pkg::POS_W'(sfr_pkg::FRAME_BYTES - 1));

	always_comb begin
		pos_d = pos_q;
		crc_d = crc_q;
		store_en = 1'b0;
		case (sfr_pkg::op_t'(operation))
			sfr_pkg::OP_BYTE: begin
				if (pos_q == sfr_pkg::POS_W'(0) || last_byte ||
						(pos_q == sfr_pkg::POS_W'(1) && rx_byte != sfr_pkg::HDR_SECOND)) begin
					if (rx_byte == sfr_pkg::HDR_FIRST) begin
						pos_d = sfr_pkg::POS_W'(1);
						crc_d = crc_first;
					end else begin
						pos_d = '0;
					end
				end else if (pos_q >= sfr_pkg::POS_W'(sfr_pkg::FRAME_BYTES)) begin
					pos_d = '0;
				end else begin
					store_en = (pos_q != sfr_pkg::POS_W'(1));
					crc_d = sfr_pkg::crc_step(crc_q, rx_byte);
					pos_d = pos_q + sfr_pkg::POS_W'(1);
				end
			end
			sfr_pkg::OP_OVERFLOW: begin
				pos_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
		end else if (take) begin
			pos_q <= pos_d;
			crc_q <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && store_en) begin
			frame_q[pos_q] <= rx_byte;
		end
	end

	always_comb begin
		push = take && ((sfr_pkg::op_t'(operation) == sfr_pkg::OP_TIME) ||
			(sfr_pkg::op_t'(operation) == sfr_pkg::OP_BYTE && last_byte));
		job.kind = (sfr_pkg::op_t'(operation) == sfr_pkg::OP_TIME) ?
			sfr_pkg::JOB_TIME : sfr_pkg::JOB_FRAME;
		job.crc_ok = (crc_q == rx_byte);
		job.status = frame_q[2];
		job.seq = frame_q[3];
		job.pos = {frame_q[5], frame_q[4]};
		job.vel = {frame_q[7], frame_q[6]};
		job.conf = frame_q[8];
		job.px = {frame_q[10], frame_q[9]};
		job.py = {frame_q[12], frame_q[11]};
		job.now = now_ms;
	end

endmodule

// ----- hdl/sfr_queue.sv -----
// Two-entry job queue between the front end and the back end.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output sfr_pkg::job_t head
);

	sfr_pkg::job_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;

	assign full = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// ----- hdl/sfr_back.sv -----
// Back end: CRC and status verdict, sequence tracking, link timeout and the result register.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      timeout_limit_q,
	input  logic [15:0]      lost_pixel_q,
	input  logic             avail,
	input  sfr_pkg::job_t    head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output sfr_pkg::result_t res
);

	logic [7:0]  prev_seq_q;
	logic        seq_valid_q;
	logic [31:0] adv_time_q;
	logic [31:0] last_frame_q;
	logic        frame_seen_q;
	logic        timed_out_q;
	logic        valid_q;
	sfr_pkg::result_t res_q;

	logic             emit;
	logic             good;
	logic             advance;
	logic             timeout_hit;
	logic [31:0]      adv_time_d;
	sfr_pkg::result_t res_d;

	assign pop = avail && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign res = res_q;

	always_comb begin
		good = (head.kind == sfr_pkg::JOB_FRAME) && head.crc_ok &&
			(head.status <= sfr_pkg::STATUS_MAX);
		advance = good && (!seq_valid_q || head.seq != prev_seq_q);
		adv_time_d = advance ? head.now : adv_time_q;
		timeout_hit = (head.kind == sfr_pkg::JOB_TIME) && frame_seen_q && !timed_out_q &&
			((head.now - last_frame_q) > timeout_limit_q);
		emit = (head.kind == sfr_pkg::JOB_FRAME) || timeout_hit;

		res_d = '0;
		if (head.kind == sfr_pkg::JOB_TIME) begin
			res_d.ev = sfr_pkg::EV_TIMEOUT;
		end else if (!head.crc_ok) begin
			res_d.ev = sfr_pkg::EV_CRC_ERR;
		end else if (!good) begin
			res_d.ev = sfr_pkg::EV_STATUS_ERR;
		end else begin
			res_d.ev = timed_out_q ? sfr_pkg::EV_RECOVERED : sfr_pkg::EV_VALID;
			res_d.status = head.status[1:0];
			res_d.seq = head.seq;
			res_d.pos = head.pos;
			res_d.vel = head.vel;
			res_d.conf = head.conf;
			res_d.px = head.px;
			res_d.py = head.py;
			res_d.adv = advance;
			res_d.gap = advance && seq_valid_q && (head.seq != prev_seq_q + 8'd1);
			res_d.lost_ok = (head.status != sfr_pkg::STATUS_LOST) ||
				(head.pos == '0 && head.vel == '0 && head.conf == '0 &&
				head.px == lost_pixel_q && head.py == lost_pixel_q);
			res_d.age = head.now - adv_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_q <= '0;
			seq_valid_q <= 1'b0;
			adv_time_q <= '0;
			last_frame_q <= '0;
			frame_seen_q <= 1'b0;
			timed_out_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= emit;
				if (advance) begin
					prev_seq_q <= head.seq;
					seq_valid_q <= 1'b1;
					adv_time_q <= head.now;
				end
				if (good) begin
					timed_out_q <= 1'b0;
					last_frame_q <= head.now;
					frame_seen_q <= 1'b1;
				end else if (timeout_hit) begin
					timed_out_q <= 1'b1;
				end
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- hdl/sensor_frame_receiver_crc8_unit.sv -----
// Top level of the sensor frame receiver: configuration registers and the
// front end, job queue and back end. Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back.
`timescale 1ns / 1ps

// Takes one item per clock while in_stall is low: received bytes, time checks
// and overflow notices. The front end tracks the header and running CRC-8 at
// one byte per item and hands completed frames and time checks to a two-entry
// queue; the back end, when not stalled, retires one job per cycle into the
// output register. in_stall rises only while the queue is full, which happens
// only when out_stall holds the result register. The configuration port is
// always ready; users write only while idle, which the block does not enforce.

module sensor_frame_receiver_crc8_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [7:0]                    rx_byte,
	input  logic [31:0]                   now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_res,
	output logic [1:0]                    frame_status,
	output logic [7:0]                    sequence_number,
	output logic signed [15:0]            position_tenth_mm,
	output logic signed [15:0]            velocity_tenth_mm_s,
	output logic [7:0]                    confidence_level,
	output logic [15:0]                   pixel_x,
	output logic [15:0]                   pixel_y,
	output logic                          sequence_advanced,
	output logic                          sequence_gap,
	output logic                          lost_payload_ok,
	output logic [31:0]                   sequence_age_ms,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	logic [31:0]      timeout_limit_q;
	logic [15:0]      lost_pixel_q;
	logic             take;
	logic             push;
	logic             full;
	logic             pop;
	logic             avail;
	sfr_pkg::job_t    push_job;
	sfr_pkg::job_t    head;
	sfr_pkg::result_t res;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign take = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= 32'd100;
			lost_pixel_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (sfr_pkg::reg_idx_t'(cfg_index))
				sfr_pkg::REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data;
				sfr_pkg::REG_LOST_PIXEL: lost_pixel_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	sfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.operation (operation),
		.rx_byte   (rx_byte),
		.now_ms    (now_ms),
		.push      (push),
		.job       (push_job)
	);

	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	sfr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.timeout_limit_q (timeout_limit_q),
		.lost_pixel_q    (lost_pixel_q),
		.avail           (avail),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.res             (res)
	);

	assign event_res = res.ev;
	assign frame_status = res.status;
	assign sequence_number = res.seq;
	assign position_tenth_mm = $signed(res.pos);
	assign velocity_tenth_mm_s = $signed(res.vel);
	assign confidence_level = res.conf;
	assign pixel_x = res.px;
	assign pixel_y = res.py;
	assign sequence_advanced = res.adv;
	assign sequence_gap = res.gap;
	assign lost_payload_ok = res.lost_ok;
	assign sequence_age_ms = res.age;

endmodule

// ----- tb/sv/sensor_frame_receiver_crc8_unit_test.sv -----
// Self-checking testbench for sensor_frame_receiver_crc8_unit: streams byte, time-check and
// overflow transfers, predicts every decoded sample and checks it field by field.
// Depends on sfr_pkg and the sensor_frame_receiver_crc8_unit RTL.
`timescale 1ns / 1ps

module sensor_frame_receiver_crc8_unit_test;
	import sfr_pkg::*;

	localparam int STUCK_LIMIT = 4000;
	localparam int PHASE_ITEMS = 225;

	typedef struct {
		op_t         op;
		logic [7:0]  b;
		logic [31:0] now;
	} link_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] operation = '0;
	logic [7:0] rx_byte = '0;
	logic [31:0] now_ms = '0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic in_stall, out_valid, cfg_ready;
	logic [2:0] event_res;
	logic [1:0] frame_status;
	logic [7:0] sequence_number, confidence_level;
	logic signed [15:0] position_tenth_mm, velocity_tenth_mm_s;
	logic [15:0] pixel_x, pixel_y;
	logic sequence_advanced, sequence_gap, lost_payload_ok;
	logic [31:0] sequence_age_ms;

	sensor_frame_receiver_crc8_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .rx_byte(rx_byte), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .frame_status(frame_status),
		.sequence_number(sequence_number), .position_tenth_mm(position_tenth_mm),
		.velocity_tenth_mm_s(velocity_tenth_mm_s), .confidence_level(confidence_level),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.sequence_advanced(sequence_advanced), .sequence_gap(sequence_gap),
		.lost_payload_ok(lost_payload_ok), .sequence_age_ms(sequence_age_ms),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// receiver state as predicted, at its reset values
	int          parse_pos = 0;
	logic [7:0]  parse_crc = '0;
	logic [7:0]  parse_bytes [FRAME_BYTES];
	logic [7:0]  prev_seq = '0;
	logic        seq_valid = 1'b0;
	logic [31:0] adv_ms = '0;
	logic [31:0] last_frame_ms = '0;
	logic        frame_seen = 1'b0;
	logic        timed_out = 1'b0;
	logic [31:0] timeout_limit = 32'd100;
	logic [15:0] lost_code = 16'hFFFF;

	result_t     expected_samples [$];
	link_item_t  pending_items [$];
	int          mismatches = 0;
	int          stuck_cycles = 0;
	logic        in_taken = 1'b0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	// stimulus generator state
	logic [31:0] gen_now = '0;
	logic [31:0] last_byte_ms = '0;
	logic [31:0] last_good_ms = '0;
	logic [7:0]  gen_seq = '0;
	logic [31:0] gen_limit = 32'd100;
	logic [15:0] gen_lost = 16'hFFFF;
	int          queued_count = 0;
	logic [7:0]  tx_frame [FRAME_BYTES];

	function automatic logic [7:0] crc8_atm_next(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] r;
		r = acc ^ data;
		repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	function automatic void restart_hunt(input logic [7:0] b);
		if (b == HDR_FIRST) begin
			parse_bytes[0] = b;
			parse_crc = crc8_atm_next(8'h00, b);
			parse_pos = 1;
		end else begin
			parse_pos = 0;
		end
	endfunction

	task automatic receiver_step(input op_t op, input logic [7:0] b, input logic [31:0] now);
		result_t r;
		logic [7:0] seq, conf;
		logic [15:0] pos, vel, px, py;
		r = '0;
		case (op)
			OP_BYTE: begin
				if (parse_pos == 0) begin
					restart_hunt(b);
				end else if (parse_pos == 1) begin
					if (b == HDR_SECOND) begin
						parse_bytes[1] = b;
						parse_crc = crc8_atm_next(parse_crc, b);
						parse_pos = 2;
					end else begin
						restart_hunt(b);
					end
				end else if (parse_pos < FRAME_BYTES - 1) begin
					parse_bytes[parse_pos] = b;
					parse_crc = crc8_atm_next(parse_crc, b);
					parse_pos++;
				end else begin
					parse_bytes[FRAME_BYTES - 1] = b;
					if (parse_crc != b) begin
						r.ev = EV_CRC_ERR;
					end else if (parse_bytes[2] > STATUS_MAX) begin
						r.ev = EV_STATUS_ERR;
					end else begin
						seq = parse_bytes[3];
						pos = {parse_bytes[5], parse_bytes[4]};
						vel = {parse_bytes[7], parse_bytes[6]};
						conf = parse_bytes[8];
						px = {parse_bytes[10], parse_bytes[9]};
						py = {parse_bytes[12], parse_bytes[11]};
						r.ev = timed_out ? EV_RECOVERED : EV_VALID;
						r.status = parse_bytes[2][1:0];
						r.seq = seq;
						r.pos = pos;
						r.vel = vel;
						r.conf = conf;
						r.px = px;
						r.py = py;
						r.lost_ok = !(parse_bytes[2] == STATUS_LOST && !(pos == 0 && vel == 0
							&& conf == 0 && px == lost_code && py == lost_code));
						if (!seq_valid) begin
							seq_valid = 1'b1;
							prev_seq = seq;
							adv_ms = now;
							r.adv = 1'b1;
						end else if (seq != prev_seq) begin
							r.gap = (seq != prev_seq + 8'd1);
							prev_seq = seq;
							adv_ms = now;
							r.adv = 1'b1;
						end
						r.age = now - adv_ms;
						timed_out = 1'b0;
						last_frame_ms = now;
						frame_seen = 1'b1;
					end
					expected_samples.push_back(r);
					restart_hunt(b);
				end
			end
			OP_TIME: begin
				if (frame_seen && !timed_out && (now - last_frame_ms) > timeout_limit) begin
					timed_out = 1'b1;
					r.ev = EV_TIMEOUT;
					expected_samples.push_back(r);
				end
			end
			OP_OVERFLOW: begin
				parse_pos = 0;
			end
			default: begin
			end
		endcase
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// drive: advance only once the presented transfer has been taken
	always @(negedge clk) begin : driver
		link_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = pending_items.pop_front();
				in_valid <= 1'b1;
				operation <= item.op;
				rx_byte <= item.b;
				now_ms <= item.now;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : monitor
		result_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				receiver_step(op_t'(operation), rx_byte, now_ms);
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$error("result with no expectation: event_res %0d", event_res);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					compare_field("event_res", want.ev, event_res);
					compare_field("frame_status", want.status, frame_status);
					compare_field("sequence_number", want.seq, sequence_number);
					compare_field("position_tenth_mm", want.pos, $unsigned(position_tenth_mm));
					compare_field("velocity_tenth_mm_s", want.vel,
						$unsigned(velocity_tenth_mm_s));
					compare_field("confidence_level", want.conf, confidence_level);
					compare_field("pixel_x", want.px, pixel_x);
					compare_field("pixel_y", want.py, pixel_y);
					compare_field("sequence_advanced", want.adv, sequence_advanced);
					compare_field("sequence_gap", want.gap, sequence_gap);
					compare_field("lost_payload_ok", want.lost_ok, lost_payload_ok);
					compare_field("sequence_age_ms", want.age, sequence_age_ms);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| (pending_items.size() == 0 && !in_valid && expected_samples.size() == 0)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("sensor_frame_receiver_crc8_unit_test failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	task automatic write_register(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TIMEOUT_LIMIT: timeout_limit = data;
			REG_LOST_PIXEL: lost_code = data[15:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_until_idle();
		while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void queue_item(input op_t op, input logic [7:0] b);
		link_item_t item;
		item.op = op;
		item.b = b;
		item.now = gen_now;
		last_byte_ms = gen_now;
		gen_now += 32'($urandom_range(2));
		pending_items.push_back(item);
		if (op != OP_UNUSED)
			queued_count++;
	endfunction

	function automatic logic [7:0] tx_frame_crc();
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			c = crc8_atm_next(c, tx_frame[i]);
		return c;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// tail: close the frame with a header byte; skip_lead: the header byte was already sent
	function automatic void queue_frame(input logic [7:0] status, input logic [7:0] seq,
		input logic [15:0] pos, input logic [15:0] vel, input logic [7:0] conf,
		input logic [15:0] px, input logic [15:0] py, input bit bad, input bit tail,
		input bit skip_lead, input int cut);
		tx_frame = '{HDR_FIRST, HDR_SECOND, status, seq, pos[7:0], pos[15:8], vel[7:0],
			vel[15:8], conf, px[7:0], px[15:8], py[7:0], py[15:8], 8'h00};
		if (tail && !bad) begin
			for (int v = 0; v < 256; v++) begin
				tx_frame[12] = 8'(v);
				if (tx_frame_crc() == HDR_FIRST)
					break;
			end
			tx_frame[13] = HDR_FIRST;
		end else if (tail) begin
			if (tx_frame_crc() == HDR_FIRST)
				tx_frame[12] ^= 8'h01;
			tx_frame[13] = HDR_FIRST;
		end else begin
			tx_frame[13] = tx_frame_crc();
			if (bad)
				tx_frame[13] ^= 8'($urandom_range(1, 255));
		end
		for (int i = skip_lead ? 1 : 0; i < cut; i++)
			queue_item(OP_BYTE, tx_frame[i]);
		if (cut == FRAME_BYTES && !bad && status <= STATUS_MAX) begin
			last_good_ms = last_byte_ms;
			gen_seq = seq;
		end
	endfunction

	function automatic bit queue_random_frame(input bit skip_lead, input int cut);
		logic [7:0] status, seq, conf;
		logic [15:0] pos, vel, px, py;
		int pick;
		bit tail;
		status = ($urandom_range(99) < 85) ? 8'($urandom_range(2)) : 8'($urandom_range(3, 255));
		pick = $urandom_range(99);
		seq = (pick < 70) ? gen_seq + 8'd1 : ((pick < 85) ? gen_seq : 8'($urandom));
		if (status == STATUS_LOST && $urandom_range(99) < 60) begin
			pos = '0;
			vel = '0;
			conf = '0;
			px = gen_lost;
			py = gen_lost;
		end else begin
			pos = pick_word();
			vel = pick_word();
			conf = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom);
			px = pick_word();
			py = pick_word();
		end
		tail = (cut == FRAME_BYTES) && ($urandom_range(99) < 10);
		queue_frame(status, seq, pos, vel, conf, px, py, $urandom_range(99) < 12, tail,
			skip_lead, cut);
		return tail;
	endfunction

	function automatic void queue_random_traffic(input int target);
		int start, pick;
		bit chained;
		start = queued_count;
		while (queued_count - start < target) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				chained = 1'b0;
				do chained = queue_random_frame(chained, FRAME_BYTES); while (chained);
			end else if (pick < 77) begin
				case ($urandom_range(5))
					0: gen_now = last_good_ms + gen_limit;
					1: gen_now = last_good_ms + gen_limit + 32'd1;
					2: gen_now = last_good_ms + gen_limit - 32'd1;
					3: gen_now += 32'($urandom_range(300));
					4: gen_now = $urandom;
					default: gen_now = last_good_ms + gen_limit + 32'($urandom_range(2, 50));
				endcase
				queue_item(OP_TIME, 8'($urandom));
			end else if (pick < 83) begin
				void'(queue_random_frame(1'b0, $urandom_range(1, FRAME_BYTES - 1)));
				queue_item(OP_OVERFLOW, 8'($urandom));
			end else if (pick < 89) begin
				void'(queue_random_frame(1'b0, $urandom_range(1, FRAME_BYTES - 1)));
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(3))
						0: queue_item(OP_BYTE, HDR_FIRST);
						1: queue_item(OP_BYTE, HDR_SECOND);
						default: queue_item(OP_BYTE, 8'($urandom));
					endcase
				end
			end else begin
				queue_item(OP_UNUSED, 8'($urandom));
				queue_item(OP_OVERFLOW, 8'($urandom));
			end
		end
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no frame seen yet, ignored operation, hunting noise
		queue_item(OP_TIME, 8'h00);
		queue_item(OP_UNUSED, 8'hFF);
		queue_item(OP_OVERFLOW, 8'h00);
		queue_item(OP_BYTE, 8'h13);
		// repeated header byte, then a canonical lost frame
		queue_item(OP_BYTE, HDR_FIRST);
		queue_frame(STATUS_LOST, 8'hFF, 16'h0000, 16'h0000, 8'h00, 16'hFFFF, 16'hFFFF,
			1'b0, 1'b0, 1'b0, FRAME_BYTES);
		// right at the limit, then one past it
		gen_now = last_good_ms + 32'd100;
		queue_item(OP_TIME, 8'hFF);
		gen_now = last_good_ms + 32'd101;
		queue_item(OP_TIME, 8'h00);
		// drop a frame in flight
		queue_item(OP_BYTE, HDR_FIRST);
		queue_item(OP_BYTE, HDR_SECOND);
		queue_item(OP_BYTE, 8'h02);
		queue_item(OP_OVERFLOW, 8'hFF);
		wait_until_idle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 63;
				end
				default: begin
					send_idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			case (phase)
				0: begin
					gen_limit = 32'd100;
					gen_lost = 16'hFFFF;
				end
				1: begin
					gen_limit = 32'd0;
					gen_lost = 16'h0000;
				end
				2: begin
					gen_limit = 32'hFFFF_FFFF;
					gen_lost = 16'hFFFF;
				end
				3: begin
					gen_limit = $urandom_range(1, 400);
					gen_lost = 16'($urandom);
				end
				4: begin
					gen_limit = 32'd1;
					gen_lost = 16'h8000;
				end
				5: begin
					gen_limit = $urandom;
					gen_lost = 16'($urandom);
				end
				6: begin
					gen_limit = $urandom_range(20, 200);
					gen_lost = 16'h0001;
				end
				default: begin
					gen_limit = 32'd100;
					gen_lost = 16'hFFFF;
				end
			endcase
			write_register(REG_TIMEOUT_LIMIT, gen_limit);
			write_register(REG_LOST_PIXEL, {16'h0000, gen_lost});
			queue_random_traffic(PHASE_ITEMS);
			wait_until_idle();
		end

		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("sensor_frame_receiver_crc8_unit_test passed");
		else
			$display("sensor_frame_receiver_crc8_unit_test failed");
		$finish;
	end

endmodule

// ----- sensor_frame_receiver_crc8_unit.f -----
hdl/sfr_pkg.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/sensor_frame_receiver_crc8_unit.sv
tb/sv/sensor_frame_receiver_crc8_unit_test.sv
